// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by drive_command_slew_limiter, clocked on clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/dcsl_pkg.sv
// ----------------------------------------------------------------------------
// dcsl_pkg
// types and constants for the drive command slew limiter
// ----------------------------------------------------------------------------
package dcsl_pkg;

  localparam int SPEED_W = 9;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [SPEED_W-1:0] speed_t;

  // request kinds
  localparam logic MODE_CMD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // ascii drive commands
  localparam logic [7:0] CMD_FWD   = 8'h46;
  localparam logic [7:0] CMD_BACK  = 8'h42;
  localparam logic [7:0] CMD_LEFT  = 8'h4C;
  localparam logic [7:0] CMD_RIGHT = 8'h52;
  localparam logic [7:0] CMD_STOP  = 8'h53;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP   = 2'd1;

  localparam logic [7:0] DRIVE_SPEED_RST = 8'd180;
  localparam logic [7:0] RAMP_STEP_RST   = 8'd15;

  typedef struct packed {
    logic   load;
    speed_t left;
    speed_t right;
  } tgt_upd_t;

  typedef struct packed {
    logic       fwd;
    logic [7:0] duty;
  } drive_t;

endpackage

// File: hdl/dcsl_slew.sv
// ----------------------------------------------------------------------------
// dcsl_slew
// one motor: step current speed toward target, clamp, sign-magnitude drive
// ----------------------------------------------------------------------------
module dcsl_slew
  import dcsl_pkg::*;
(
  input  speed_t     cur,
  input  speed_t     tgt,
  input  logic [7:0] step,
  output speed_t     cur_nxt,
  output drive_t     drive
);

  logic signed [SPEED_W:0] cur_x;
  logic signed [SPEED_W:0] tgt_x;
  logic signed [SPEED_W:0] step_x;
  logic signed [SPEED_W:0] sum;
  logic signed [SPEED_W:0] diff;
  logic [SPEED_W-1:0]      mag;

  assign cur_x  = {cur[SPEED_W-1], cur};
  assign tgt_x  = {tgt[SPEED_W-1], tgt};
  assign step_x = $signed({2'b00, step});
  assign sum    = cur_x + step_x;
  assign diff   = cur_x - step_x;

  always_comb begin
    if (cur < tgt) begin
      cur_nxt = (sum > tgt_x) ? tgt : speed_t'(sum[SPEED_W-1:0]);
    end else if (cur > tgt) begin
      cur_nxt = (diff < tgt_x) ? tgt : speed_t'(diff[SPEED_W-1:0]);
    end else begin
      cur_nxt = cur;
    end
  end

  // speed never leaves -255..255, so the magnitude fits in 8 bits
  assign mag        = cur_nxt[SPEED_W-1] ? 9'(-cur_nxt) : 9'(cur_nxt);
  assign drive.fwd  = ~cur_nxt[SPEED_W-1];
  assign drive.duty = mag[7:0];

endmodule

// File: hdl/dcsl_cmd.sv
// ----------------------------------------------------------------------------
// dcsl_cmd
// decodes an ascii drive command into new left and right targets
// ----------------------------------------------------------------------------
module dcsl_cmd
  import dcsl_pkg::*;
(
  input  logic [7:0] cmd,
  input  logic [7:0] drive_speed,
  output tgt_upd_t   upd
);

  speed_t pos;
  speed_t neg;

  assign pos = speed_t'({1'b0, drive_speed});
  assign neg = -pos;

  always_comb begin
    upd.load  = 1'b1;
    upd.left  = '0;
    upd.right = '0;
    case (cmd)
      CMD_FWD: begin
        upd.left  = pos;
        upd.right = pos;
      end
      CMD_BACK: begin
        upd.left  = neg;
        upd.right = neg;
      end
      CMD_LEFT: begin
        upd.left  = neg;
        upd.right = pos;
      end
      CMD_RIGHT: begin
        upd.left  = pos;
        upd.right = neg;
      end
      CMD_STOP: begin
        upd.left  = '0;
        upd.right = '0;
      end
      default: begin
        upd.load = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/drive_command_slew_limiter.sv
// ----------------------------------------------------------------------------
// drive_command_slew_limiter
// Two-motor drive with slew limiting. A command request ('F','B','L','R','S')
// sets the left and right target speeds to +/-drive_speed or zero and gives
// no result; other bytes are ignored. A tick request moves each current
// speed toward its target by at most the ramp step without overshoot and
// gives one result: direction bit and 8-bit duty per motor. Each request
// waits in the input register and is processed as it leaves it;
// a tick's result sits in the output register the next cycle. One request
// per cycle is sustained, limited only by the output register while
// out_stall is high (commands pass through even then). Configuration writes
// are always taken and should only be made while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drive_command_slew_limiter
  import dcsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [7:0]           in_command_byte,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_left_forward,
  output logic [7:0]           out_left_duty,
  output logic                 out_right_forward,
  output logic [7:0]           out_right_duty,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] drive_speed_r;
  logic [7:0] ramp_step_r;

  logic       in_vld_r, in_vld_nxt;
  logic       in_mode_r;
  logic [7:0] in_cmd_r;

  logic       out_vld_r, out_vld_nxt;
  drive_t     left_drv_r, right_drv_r;

  speed_t     left_tgt_r, right_tgt_r;
  speed_t     left_cur_r, right_cur_r;
  speed_t     left_cur_nxt, right_cur_nxt;
  drive_t     left_drv, right_drv;
  tgt_upd_t   upd;

  logic       adv_w;
  logic       take_w;
  logic       is_tick;
  logic       tick_adv;
  logic       cmd_adv;
  logic       out_hold;
  logic       left_below;

  assign is_tick = (in_mode_r == MODE_TICK);
  // commands never touch the output register, so they move on regardless
  assign adv_w   = in_vld_r && (!is_tick || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv_w;
  assign take_w  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign tick_adv   = adv_w && is_tick;
  assign cmd_adv    = adv_w && !is_tick;
  assign out_hold   = out_vld_r && out_stall;
  assign left_below = (left_cur_r <= left_tgt_r);

  assign in_vld_nxt  = take_w || (in_vld_r && !adv_w);
  assign out_vld_nxt = tick_adv || out_hold;

  dcsl_cmd u_cmd (
    .cmd         (in_cmd_r),
    .drive_speed (drive_speed_r),
    .upd         (upd)
  );

  dcsl_slew u_slew_left (
    .cur     (left_cur_r),
    .tgt     (left_tgt_r),
    .step    (ramp_step_r),
    .cur_nxt (left_cur_nxt),
    .drive   (left_drv)
  );

  dcsl_slew u_slew_right (
    .cur     (right_cur_r),
    .tgt     (right_tgt_r),
    .step    (ramp_step_r),
    .cur_nxt (right_cur_nxt),
    .drive   (right_drv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_speed_r <= DRIVE_SPEED_RST;
      ramp_step_r   <= RAMP_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DRIVE_SPEED: drive_speed_r <= cfg_data;
        CFG_RAMP_STEP:   ramp_step_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      left_tgt_r  <= '0;
      right_tgt_r <= '0;
      left_cur_r  <= '0;
      right_cur_r <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cmd_adv && upd.load) begin
        left_tgt_r  <= upd.left;
        right_tgt_r <= upd.right;
      end
      if (tick_adv) begin
        left_cur_r  <= left_cur_nxt;
        right_cur_r <= right_cur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_w) begin
      in_mode_r <= in_mode;
      in_cmd_r  <= in_command_byte;
    end
    if (tick_adv) begin
      left_drv_r  <= left_drv;
      right_drv_r <= right_drv;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_left_forward  = left_drv_r.fwd;
  assign out_left_duty     = left_drv_r.duty;
  assign out_right_forward = right_drv_r.fwd;
  assign out_right_duty    = right_drv_r.duty;

  `ASSERT_CLK(a_tick_gives_result, tick_adv |=> out_vld_r, "tick request lost its result")
  `ASSERT_CLK(a_cmd_no_result, cmd_adv |=> out_vld_r == $past(out_hold), "command gave a result")
  `ASSERT_CLK(a_no_overshoot, (tick_adv && left_below) |=> left_below, "left speed overshot")
  `ASSERT_ALWAYS(a_rst_clears, !rst_n |=> (!out_vld_r && !in_vld_r), "reset left a valid set")

endmodule
